// File: rtl/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_SLAVE = 1'b0;
  localparam logic REG_FUNC  = 1'b1;

  localparam logic [7:0] SLAVE_RST = 8'd1;
  localparam logic [7:0] FUNC_RST  = 8'd3;

  localparam logic [7:0] FN_READ_COILS    = 8'd1;
  localparam logic [7:0] FN_READ_INPUTS   = 8'd2;
  localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
  localparam logic [7:0] FN_READ_INPUT_RG = 8'd4;

  localparam int FN_EXC_BIT = 7;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_ADDR   = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_EXCEPT = 3'd4;
  localparam logic [2:0] ST_LENGTH = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CW    = 3;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] payload_value;
    logic [2:0]  status_code;
    logic [7:0]  exception_value;
    logic [15:0] detail_value;
    logic [7:0]  payload_length;
    logic        last_item;
  } out_item_t;

  typedef struct packed {
    logic      pay_valid;
    out_item_t pay_item;
    logic      sta_valid;
    out_item_t sta_item;
  } push_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/modbus_rtu_response_checker.sv
// Modbus RTU response checker: takes one frame byte per cycle with a frame_end flag on the
// last byte, runs the reflected CRC-16 over the whole frame and checks for a zero residue,
// and returns payload words (register words for reads 3/4, raw bytes after the byte count for
// reads 1/2, raw bytes after the function code otherwise) as they are confirmed, followed by
// one status word per frame (overflow, short, address, crc, exception, byte count, in that
// order). Payload words are tentative until an ok status arrives. A byte passes an input
// register and is processed from there, so one byte is taken per cycle while there is room; a byte
// can yield two result words, which drain from a four-entry output queue at one per cycle while
// out_ready is high, and input is held off while that queue has fewer than two free entries.
// expected_slave sits at address 0 and expected_function at address 4 of the register port.
`default_nettype none

module modbus_rtu_response_checker #(
  parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 rx_byte,
  input  wire logic                       frame_end,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            result_kind,
  output logic      [15:0]                payload_value,
  output logic      [2:0]                 status_code,
  output logic      [7:0]                 exception_value,
  output logic      [15:0]                detail_value,
  output logic      [7:0]                 payload_length,
  output logic                            last_item,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mrc_pkg::APB_AW-1:0] paddr,
  input  wire logic [mrc_pkg::APB_DW-1:0] pwdata,
  output logic      [mrc_pkg::APB_DW-1:0] prdata,
  output logic                            pready
);

  logic [7:0]         expected_slave;
  logic [7:0]         expected_function;
  logic               room;
  mrc_pkg::push_t     push;
  mrc_pkg::out_item_t head;

  mrc_cfg_regs u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .expected_slave    (expected_slave),
    .expected_function (expected_function)
  );

  mrc_frame_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .frame_end         (frame_end),
    .expected_slave    (expected_slave),
    .expected_function (expected_function),
    .room              (room),
    .push              (push)
  );

  mrc_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign result_kind     = head.result_kind;
  assign payload_value   = head.payload_value;
  assign status_code     = head.status_code;
  assign exception_value = head.exception_value;
  assign detail_value    = head.detail_value;
  assign payload_length  = head.payload_length;
  assign last_item       = head.last_item;

endmodule

`default_nettype wire

// File: rtl/mrc_cfg_regs.sv
`default_nettype none

module mrc_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mrc_pkg::APB_AW-1:0] paddr,
  input  wire logic [mrc_pkg::APB_DW-1:0] pwdata,
  output logic      [mrc_pkg::APB_DW-1:0] prdata,
  output logic                            pready,
  output logic      [7:0]                 expected_slave,
  output logic      [7:0]                 expected_function
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_slave    <= mrc_pkg::SLAVE_RST;
      expected_function <= mrc_pkg::FUNC_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mrc_pkg::REG_SLAVE: expected_slave    <= pwdata[7:0];
        mrc_pkg::REG_FUNC:  expected_function <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mrc_pkg::REG_SLAVE: prdata = {24'h000000, expected_slave};
      mrc_pkg::REG_FUNC:  prdata = {24'h000000, expected_function};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mrc_frame_core.sv
`default_nettype none

module mrc_frame_core #(
  parameter int MAX_FRAME_BYTES = mrc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    rx_byte,
  input  wire logic          frame_end,
  input  wire logic [7:0]    expected_slave,
  input  wire logic [7:0]    expected_function,
  input  wire logic          room,
  output mrc_pkg::push_t     push
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 2);
  localparam int CW = (PW > 8) ? PW : 8;
  localparam int LW = CW + 1;
  localparam logic [PW-1:0] MAX_POS = PW'(MAX_FRAME_BYTES);
  localparam logic [PW-1:0] OVF_POS = PW'(MAX_FRAME_BYTES + 1);

  logic          s_valid;
  logic [7:0]    s_byte;
  logic          s_end;
  logic          go;

  logic [15:0]   crc, crc_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    held0, held0_next;
  logic [7:0]    held1, held1_next;
  logic [7:0]    addr_b, addr_b_next;
  logic [7:0]    func_b, func_b_next;
  logic [7:0]    count_b, count_b_next;
  logic [7:0]    pend, pend_next;

  logic          is_reg;
  logic          is_bit;
  logic          enable;
  logic [PW-1:0] k;
  logic [PW-1:0] d;
  logic [PW-1:0] len;
  logic          pay_emit;
  logic [15:0]   pay_val;
  mrc_pkg::out_item_t sta;

  assign go       = s_valid && room;
  assign in_ready = !s_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_byte <= rx_byte;
      s_end  <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc     <= mrc_pkg::CRC_INIT;
      pos     <= '0;
      held0   <= '0;
      held1   <= '0;
      addr_b  <= '0;
      func_b  <= '0;
      count_b <= '0;
      pend    <= '0;
    end else if (go) begin
      crc     <= crc_next;
      pos     <= pos_next;
      held0   <= held0_next;
      held1   <= held1_next;
      addr_b  <= addr_b_next;
      func_b  <= func_b_next;
      count_b <= count_b_next;
      pend    <= pend_next;
    end
  end

  assign is_reg = (expected_function == mrc_pkg::FN_READ_HOLDING) ||
                  (expected_function == mrc_pkg::FN_READ_INPUT_RG);
  assign is_bit = (expected_function == mrc_pkg::FN_READ_COILS) ||
                  (expected_function == mrc_pkg::FN_READ_INPUTS);
  assign enable = (addr_b == expected_slave) && !func_b[mrc_pkg::FN_EXC_BIT];
  assign k      = pos - PW'(2);
  assign d      = pos - PW'(5);

  always_comb begin
    crc_next     = crc;
    pos_next     = pos;
    held0_next   = held0;
    held1_next   = held1;
    addr_b_next  = addr_b;
    func_b_next  = func_b;
    count_b_next = count_b;
    pend_next    = pend;
    pay_emit     = 1'b0;
    pay_val      = '0;
    len          = '0;
    sta          = '0;

    // body byte handling
    if (pos < MAX_POS) begin
      crc_next = mrc_pkg::crc_feed(crc, s_byte);
      pos_next = pos + PW'(1);
      if (pos >= PW'(2)) begin
        held0_next = held1;
        held1_next = s_byte;
        if (k == PW'(0)) begin
          addr_b_next = held0;
        end else if (k == PW'(1)) begin
          func_b_next = held0;
        end else begin
          if (k == PW'(2)) begin
            count_b_next = held0;
          end
          if (k == PW'(2) && (is_reg || is_bit)) begin
            pay_emit = 1'b0;
          end else if (enable) begin
            if (is_reg || is_bit) begin
              if (CW'(d) < CW'(count_b)) begin
                if (is_bit) begin
                  pay_emit = 1'b1;
                  pay_val  = {8'h00, held0};
                end else if (!d[0]) begin
                  pend_next = held0;
                end else begin
                  pay_emit = 1'b1;
                  pay_val  = {pend, held0};
                end
              end
            end else begin
              pay_emit = 1'b1;
              pay_val  = {8'h00, held0};
            end
          end
        end
      end else if (!pos[0]) begin
        held0_next = s_byte;
      end else begin
        held1_next = s_byte;
      end
    end else begin
      pos_next = OVF_POS;
    end

    // frame status
    if (s_end) begin
      len             = pos_next;
      sta.result_kind = mrc_pkg::KIND_STATUS;
      sta.last_item   = 1'b1;
      if (len > MAX_POS) begin
        sta.status_code  = mrc_pkg::ST_LENGTH;
        sta.detail_value = 16'(len);
      end else if (len < PW'(4)) begin
        sta.status_code  = mrc_pkg::ST_SHORT;
        sta.detail_value = 16'(len);
      end else if (addr_b_next != expected_slave) begin
        sta.status_code  = mrc_pkg::ST_ADDR;
        sta.detail_value = {8'h00, addr_b_next};
      end else if (crc_next != 16'h0000) begin
        sta.status_code  = mrc_pkg::ST_CRC;
        sta.detail_value = {held1_next, held0_next};
      end else if (func_b_next[mrc_pkg::FN_EXC_BIT]) begin
        sta.status_code     = mrc_pkg::ST_EXCEPT;
        sta.exception_value = (len >= PW'(5)) ? count_b_next : held0_next;
      end else if (is_reg || is_bit) begin
        if ((LW'(count_b_next) + LW'(5)) > LW'(len)) begin
          sta.status_code  = mrc_pkg::ST_LENGTH;
          sta.detail_value = 16'(len);
        end else begin
          sta.status_code    = mrc_pkg::ST_OK;
          sta.payload_length = count_b_next;
        end
      end else begin
        sta.status_code    = mrc_pkg::ST_OK;
        sta.payload_length = 8'(len - PW'(4));
      end

      crc_next     = mrc_pkg::CRC_INIT;
      pos_next     = '0;
      held0_next   = '0;
      held1_next   = '0;
      addr_b_next  = '0;
      func_b_next  = '0;
      count_b_next = '0;
      pend_next    = '0;
    end
  end

  always_comb begin
    push                        = '0;
    push.pay_valid              = go && pay_emit;
    push.pay_item.result_kind   = mrc_pkg::KIND_PAYLOAD;
    push.pay_item.payload_value = pay_val;
    push.sta_valid              = go && s_end;
    push.sta_item               = sta;
  end

endmodule

`default_nettype wire

// File: rtl/mrc_out_fifo.sv
`default_nettype none

module mrc_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mrc_pkg::push_t push,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_ready,
  output mrc_pkg::out_item_t  head
);

  mrc_pkg::out_item_t mem [mrc_pkg::OUT_DEPTH];

  logic [mrc_pkg::OUT_AW-1:0] wr_ptr, wr_ptr_next;
  logic [mrc_pkg::OUT_AW-1:0] rd_ptr;
  logic [mrc_pkg::OUT_CW-1:0] count, count_next;
  logic [mrc_pkg::OUT_AW-1:0] sta_addr;
  logic                       pop;

  assign out_valid   = (count != '0);
  assign pop         = out_valid && out_ready;
  assign room        = (count <= mrc_pkg::OUT_CW'(mrc_pkg::OUT_DEPTH - 2));
  assign sta_addr    = wr_ptr + mrc_pkg::OUT_AW'(push.pay_valid);
  assign wr_ptr_next = sta_addr + mrc_pkg::OUT_AW'(push.sta_valid);
  assign count_next  = count + mrc_pkg::OUT_CW'(push.pay_valid)
                     + mrc_pkg::OUT_CW'(push.sta_valid) - mrc_pkg::OUT_CW'(pop);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + mrc_pkg::OUT_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.pay_valid) begin
      mem[wr_ptr] <= push.pay_item;
    end
    if (push.sta_valid) begin
      mem[sta_addr] <= push.sta_item;
    end
  end

endmodule

`default_nettype wire
